// ===== rtl/core/tccs_pkg.sv =====
// Shared types and constants for the text console cursor and scroll engine.
// No dependencies; tccs_seq, tccs_outq and the top level import this package.
`timescale 1ns / 1ps

package tccs_pkg;

  localparam int TCCS_COLUMNS = 80;
  localparam int TCCS_ROWS    = 25;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } res_t;

endpackage

// ===== rtl/core/tccs_if.sv =====
// Valid/ready channel interfaces for the request, result and attribute ports.
// No dependencies.
`timescale 1ns / 1ps

interface tccs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;
  logic [6:0] read_col;
  logic [4:0] read_row;

  modport source (output valid, req_type, char_code, read_col, read_row, input ready);
  modport sink   (input valid, req_type, char_code, read_col, read_row, output ready);
endinterface

interface tccs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic        scrolled;

  modport source (output valid, cell_value, cursor_col, cursor_row, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_col, cursor_row, scrolled, output ready);
endinterface

interface tccs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_attr;

  modport source (output valid, color_attr, input ready);
  modport sink   (input valid, color_attr, output ready);
endinterface

// ===== rtl/core/tccs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/tccs_seq.sv =====
// Request sequencer: cursor, attribute register, screen RAM access, scroll copy and clear fill.
// Depends on tccs_pkg and tccs_ram.
`timescale 1ns / 1ps

module tccs_seq import tccs_pkg::*; #(
  parameter int COLUMNS = TCCS_COLUMNS,
  parameter int ROWS    = TCCS_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_accept,
  input  logic [1:0] req_type,
  input  logic [7:0] char_code,
  input  logic [6:0] read_col,
  input  logic [4:0] read_row,
  input  logic       cfg_wr,
  input  logic [7:0] cfg_attr,
  output logic       idle,
  output logic       res_push,
  output res_t       res
);

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int SCROLL_N = (ROWS - 1) * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(COLUMNS + 1);
  localparam int RW       = $clog2(ROWS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_CLEAR  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    attr_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;

  logic [CW-1:0] col_plus;
  logic [RW-1:0] row_plus;
  logic          wrap;
  logic [CW-1:0] put_col;
  logic [RW-1:0] put_row;
  logic          over;
  logic          rd_ok;
  logic          scr;
  logic [15:0]   rd_word;

  tccs_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  always_comb begin
    col_plus = col_r + CW'(1);
    row_plus = row_r + RW'(1);
    wrap     = (char_code == NEWLINE_CODE) || (32'(col_plus) >= COLUMNS);
    put_col  = wrap ? '0 : col_plus;
    put_row  = wrap ? row_plus : row_r;
    over     = 32'(put_row) >= ROWS;
    rd_ok    = (32'(read_col) < COLUMNS) && (32'(read_row) < ROWS);
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    addr_nxt  = addr_r;
    dst_nxt   = dst_r;
    pend_nxt  = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;
    res_push  = 1'b0;
    scr       = 1'b0;
    rd_word   = '0;
    case (state_r)
      S_IDLE: begin
        if (req_accept) begin
          case (req_type)
            REQ_PUT: begin
              if (char_code != NEWLINE_CODE) begin
                we    = 1'b1;
                waddr = AW'(32'(row_r) * COLUMNS + 32'(col_r));
                wdata = {attr_r, char_code};
              end
              col_nxt = put_col;
              if (over) begin
                row_nxt   = RW'(ROWS - 1);
                addr_nxt  = '0;
                state_nxt = S_SCROLL;
              end else begin
                row_nxt  = put_row;
                res_push = 1'b1;
              end
            end
            REQ_CLEAR: begin
              addr_nxt  = '0;
              state_nxt = S_CLEAR;
            end
            REQ_READ: begin
              if (rd_ok) begin
                raddr     = AW'(32'(read_row) * COLUMNS + 32'(read_col));
                state_nxt = S_READ;
              end else begin
                res_push = 1'b1;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        rd_word   = rdata;
        res_push  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = dst_r;
          wdata = rdata;
        end
        if (addr_r == AW'(SCROLL_N)) begin
          scr       = 1'b1;
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr    = addr_r + AW'(COLUMNS);
          pend_nxt = 1'b1;
          dst_nxt  = addr_r;
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = addr_r;
        wdata = {attr_r, SPACE_CODE};
        if (addr_r == AW'(CELLS - 1)) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res.cell_value = rd_word;
    res.cursor_col = 7'(32'(col_nxt));
    res.cursor_row = 5'(32'(row_nxt));
    res.scrolled   = scr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= 1'b0;
      attr_r  <= 8'd7;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      if (cfg_wr) begin
        attr_r <= cfg_attr;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    dst_r  <= dst_nxt;
  end

  assign idle = (state_r == S_IDLE);

endmodule

// ===== rtl/core/tccs_outq.sv =====
// Two-word result queue: output register plus skid word toward the result channel.
// Depends on tccs_pkg and tccs_if.
`timescale 1ns / 1ps

module tccs_outq import tccs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  res_t        res,
  output logic        room,
  tccs_out_if.source  out_ch
);

  res_t head_r, skid_r;
  logic head_v_r, skid_v_r;
  logic pop;

  assign pop = head_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        head_r   <= skid_r;
        skid_v_r <= push;
        if (push) begin
          skid_r <= res;
        end
      end
    end else if (push) begin
      if (head_v_r && !pop) begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end else begin
        head_r   <= res;
        head_v_r <= 1'b1;
      end
    end else if (pop) begin
      head_v_r <= 1'b0;
    end
  end

  assign room              = !skid_v_r;
  assign out_ch.valid      = head_v_r;
  assign out_ch.cell_value = head_r.cell_value;
  assign out_ch.cursor_col = head_r.cursor_col;
  assign out_ch.cursor_row = head_r.cursor_row;
  assign out_ch.scrolled   = head_r.scrolled;

endmodule

// ===== rtl/core/text_console_cursor_scroll_top.sv =====
// Text console engine top level: request, result and attribute channels.
// Depends on tccs_pkg, tccs_if, tccs_seq, tccs_outq.
//
// Usage:
//   in_ch  takes one request word: put character (newline moves to the next
//          row), clear screen, or read one cell at read_col/read_row.
//   out_ch returns one result word per request: the cell read (zero for other
//          requests), the cursor after the request and a scroll flag.
//   cfg_ch writes the attribute byte used for put and clear; write it only
//          while no request is outstanding. Reset value is 7.
// Timing:
//   A put without scroll or an out-of-range read pushes its result in the
//   cycle it is accepted; an in-range read pushes it from the registered
//   screen RAM read data in the read state. A scroll copies (ROWS-1)*COLUMNS
//   cells through the single RAM read port; a clear writes ROWS*COLUMNS cells,
//   one per cycle.
// Reset clears the cursor to row 0, column 0; screen contents are undefined
// until the first clear. When out_ch stalls, one finished result waits in
// the output register and one more in a skid word; in_ch then drops ready.
`timescale 1ns / 1ps

module text_console_cursor_scroll_top import tccs_pkg::*; #(
  parameter int COLUMNS = TCCS_COLUMNS,
  parameter int ROWS    = TCCS_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  tccs_in_if.sink    in_ch,
  tccs_out_if.source out_ch,
  tccs_cfg_if.sink   cfg_ch
);

  logic idle;
  logic room;
  logic accept;
  logic res_push;
  res_t res;

  assign in_ch.ready  = idle && room;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  tccs_seq #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_accept (accept),
    .req_type   (in_ch.req_type),
    .char_code  (in_ch.char_code),
    .read_col   (in_ch.read_col),
    .read_row   (in_ch.read_row),
    .cfg_wr     (cfg_ch.valid),
    .cfg_attr   (cfg_ch.color_attr),
    .idle       (idle),
    .res_push   (res_push),
    .res        (res)
  );

  tccs_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
